[rtl/core/cenc_pkg.sv]
// shared types, constants and aes helper functions for the subsample decryptor
// used by every module under rtl/core
package cenc_pkg;

  localparam int BlockBytes = 16;
  localparam int QueueDepth = 4;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int OffW = $clog2(BlockBytes) + 1;
  localparam int RoundW = 4;
  localparam logic [RoundW-1:0] LastRound = 4'd10;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DESC  = 2'd1,
    OP_DATA  = 2'd2
  } cenc_op_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } cenc_kind_t;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // one queued item from the front part
  typedef struct packed {
    cenc_kind_t   kind;
    logic [127:0] ctr;
    logic [7:0]   data;
    logic         dec;
    logic         last;
  } cenc_entry_t;

  // engine control from the back part
  typedef struct packed {
    logic launch;
    logic abort;
  } cenc_eng_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 sits in the top bits, column-major state
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[127 - 8 * (c * 4 + j) -: 8] = SBOX[s[127 - 8 * ((((c + j) & 3) * 4) + j) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] t);
    logic [127:0] s;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = t[127 - 32 * c -: 8];
      a1 = t[119 - 32 * c -: 8];
      a2 = t[111 - 32 * c -: 8];
      a3 = t[103 - 32 * c -: 8];
      s[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      s[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      s[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      s[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return s;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] tmp, w0, w1, w2, w3;
    tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ tmp;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/core/cenc_subsample_aes_ctr_decryptor.sv]
// top level of the cenc aes-128 ctr subsample decryptor
// items pass a queue slot and the output register; one byte per cycle sustained while
// out_ready is high and a keystream block is ready; blocks come from the iterative aes
// core, fetched ahead so 16 encrypted bytes cover one; the first encrypted byte after a
// start or key write waits for the core. start and descriptor items take no output slot
// reset (synchronous, active high) clears key, counter, counts and the queue
module cenc_subsample_aes_ctr_decryptor (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        reg_index,
  input  logic [63:0] write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] iv_high,
  input  logic [63:0] iv_low,
  input  logic        iv_short,
  input  logic [15:0] clear_count,
  input  logic [31:0] encrypted_count,
  input  logic [7:0]  data_in,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_out,
  output logic        was_decrypted,
  output logic        last_out
);

  logic                  push, q_full, pop, q_not_empty;
  cenc_pkg::cenc_entry_t push_entry, head;

  cenc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .iv_high         (iv_high),
    .iv_low          (iv_low),
    .iv_short        (iv_short),
    .clear_count     (clear_count),
    .encrypted_count (encrypted_count),
    .data_in         (data_in),
    .last_in         (last_in),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  cenc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  cenc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .write_enable  (write_enable),
    .reg_index     (reg_index),
    .write_data    (write_data),
    .q_not_empty   (q_not_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_out      (data_out),
    .was_decrypted (was_decrypted),
    .last_out      (last_out)
  );

endmodule

[rtl/core/cenc_front.sv]
// front part: accepts items, tracks subsample counts, tags each data byte
// depends on cenc_pkg
module cenc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [63:0]           iv_high,
  input  logic [63:0]           iv_low,
  input  logic                  iv_short,
  input  logic [15:0]           clear_count,
  input  logic [31:0]           encrypted_count,
  input  logic [7:0]            data_in,
  input  logic                  last_in,
  input  logic                  q_full,
  output logic                  push,
  output cenc_pkg::cenc_entry_t push_entry
);

  logic [15:0] clear_left, clear_left_next;
  logic [31:0] encrypted_left, encrypted_left_next;
  logic        desc_done, desc_done_next;
  logic        accept;
  logic        used_up;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign used_up  = desc_done || (clear_left == 16'd0 && encrypted_left == 32'd0);

  always_comb begin
    clear_left_next     = clear_left;
    encrypted_left_next = encrypted_left;
    desc_done_next      = desc_done;
    push                = 1'b0;
    push_entry.kind     = cenc_pkg::KIND_DATA;
    push_entry.ctr      = {iv_high, iv_short ? 64'd0 : iv_low};
    push_entry.data     = data_in;
    push_entry.dec      = 1'b1;
    push_entry.last     = last_in;
    if (accept) begin
      case (op)
        cenc_pkg::OP_START: begin
          clear_left_next     = '0;
          encrypted_left_next = '0;
          desc_done_next      = 1'b1;
          push                = 1'b1;
          push_entry.kind     = cenc_pkg::KIND_START;
        end
        cenc_pkg::OP_DESC: begin
          clear_left_next     = clear_count;
          encrypted_left_next = encrypted_count;
          desc_done_next      = 1'b0;
        end
        cenc_pkg::OP_DATA: begin
          push = 1'b1;
          if (used_up) begin
            desc_done_next = 1'b1;
          end else if (clear_left != 16'd0) begin
            clear_left_next = clear_left - 16'd1;
            push_entry.dec  = 1'b0;
          end else begin
            encrypted_left_next = encrypted_left - 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_left     <= '0;
      encrypted_left <= '0;
      desc_done      <= 1'b1;
    end else begin
      clear_left     <= clear_left_next;
      encrypted_left <= encrypted_left_next;
      desc_done      <= desc_done_next;
    end
  end

endmodule

[rtl/core/cenc_queue.sv]
// short fifo between the front and back parts
// depends on cenc_pkg
module cenc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cenc_pkg::cenc_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output cenc_pkg::cenc_entry_t head
);

  cenc_pkg::cenc_entry_t slots [cenc_pkg::QueueDepth];
  logic [cenc_pkg::PtrW-1:0] wr_ptr, rd_ptr;
  logic [cenc_pkg::PtrW:0]   count;

  assign full      = (count == (cenc_pkg::PtrW + 1)'(cenc_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/cenc_aes_core.sv]
// iterative aes-128 encryption, one round per cycle, round keys made on the fly
// depends on cenc_pkg
module cenc_aes_core (
  input  logic                    clk,
  input  logic                    rst,
  input  cenc_pkg::cenc_eng_ctl_t ctl,
  input  logic [127:0]            key,
  input  logic [127:0]            block_in,
  output logic                    busy,
  output logic                    done,
  output logic [127:0]            block_out
);

  logic [127:0]                state, rk, rk_next;
  logic [cenc_pkg::RoundW-1:0] round;
  logic                        running;

  assign rk_next   = cenc_pkg::key_step(rk, cenc_pkg::rcon(round));
  assign busy      = running || done;
  assign block_out = state;

  always_ff @(posedge clk) begin
    if (ctl.launch) begin
      state <= block_in ^ key;
      rk    <= key;
    end else if (running) begin
      rk <= rk_next;
      if (round == cenc_pkg::LastRound) begin
        state <= cenc_pkg::sub_shift(state) ^ rk_next;
      end else begin
        state <= cenc_pkg::mix_columns(cenc_pkg::sub_shift(state)) ^ rk_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.abort) begin
      running <= 1'b0;
      done    <= 1'b0;
      round   <= '0;
    end else if (ctl.launch) begin
      running <= 1'b1;
      done    <= 1'b0;
      round   <= 4'd1;
    end else begin
      done <= running && (round == cenc_pkg::LastRound);
      if (running) begin
        round <= round + 1'b1;
        if (round == cenc_pkg::LastRound) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/cenc_back.sv]
// back part: key registers, counter, keystream prefetch and output register
// depends on cenc_pkg and cenc_aes_core
module cenc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic                  reg_index,
  input  logic [63:0]           write_data,
  input  logic                  q_not_empty,
  input  cenc_pkg::cenc_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            data_out,
  output logic                  was_decrypted,
  output logic                  last_out
);

  logic [63:0]            key_high, key_low;
  logic [127:0]           counter, ks, pf;
  logic                   pf_valid;
  logic [cenc_pkg::OffW-1:0] offset;
  logic                   out_free, need_block, can_pop, pop_start, pop_data;
  logic                   eng_busy, eng_done;
  logic [127:0]           eng_out, sel_block, shifted;
  logic [3:0]             sel_idx;
  cenc_pkg::cenc_eng_ctl_t eng_ctl;

  assign out_free   = !out_valid || out_ready;
  assign need_block = offset[cenc_pkg::OffW-1];
  always_comb begin
    can_pop = 1'b0;
    if (head.kind == cenc_pkg::KIND_START) begin
      can_pop = 1'b1;
    end else if (!head.dec) begin
      can_pop = out_free;
    end else begin
      can_pop = out_free && (!need_block || pf_valid);
    end
  end
  assign pop       = q_not_empty && can_pop;
  assign pop_start = pop && (head.kind == cenc_pkg::KIND_START);
  assign pop_data  = pop && (head.kind == cenc_pkg::KIND_DATA);

  assign eng_ctl.abort  = pop_start || write_enable;
  assign eng_ctl.launch = !pf_valid && !eng_busy && !eng_ctl.abort;

  cenc_aes_core u_aes (
    .clk       (clk),
    .rst       (rst),
    .ctl       (eng_ctl),
    .key       ({key_high, key_low}),
    .block_in  (counter),
    .busy      (eng_busy),
    .done      (eng_done),
    .block_out (eng_out)
  );

  // a fresh block starts at its byte 0
  assign sel_block = need_block ? pf : ks;
  assign sel_idx   = need_block ? 4'd0 : offset[3:0];
  assign shifted   = sel_block << {sel_idx, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (write_enable) begin
      if (reg_index == cenc_pkg::REG_KEY_HIGH) begin
        key_high <= write_data;
      end else begin
        key_low <= write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter  <= '0;
      ks       <= '0;
      pf       <= '0;
      pf_valid <= 1'b0;
      offset   <= (cenc_pkg::OffW)'(cenc_pkg::BlockBytes);
    end else begin
      if (eng_ctl.abort) begin
        pf_valid <= 1'b0;
      end else if (eng_done) begin
        pf       <= eng_out;
        pf_valid <= 1'b1;
      end
      if (pop_start) begin
        counter <= head.ctr;
        offset  <= (cenc_pkg::OffW)'(cenc_pkg::BlockBytes);
      end else if (pop_data && head.dec) begin
        if (need_block) begin
          ks       <= pf;
          counter  <= counter + 128'd1;
          pf_valid <= 1'b0;
          offset   <= (cenc_pkg::OffW)'(1);
        end else begin
          offset <= offset + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_data) begin
      data_out      <= head.dec ? (head.data ^ shifted[127:120]) : head.data;
      was_decrypted <= head.dec;
      last_out      <= head.last;
    end
  end

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    offset <= (cenc_pkg::OffW)'(cenc_pkg::BlockBytes))
    else $error("keystream offset past block end");

  a_done_into_empty: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> !pf_valid)
    else $error("engine finished while a prefetched block was pending");

  a_start_flushes: assert property (@(posedge clk) disable iff (rst)
    pop_start |=> (need_block && !pf_valid))
    else $error("start item left stale keystream");

  a_block_used_needs_pf: assert property (@(posedge clk) disable iff (rst)
    (pop_data && head.dec && need_block) |=> (offset == (cenc_pkg::OffW)'(1)))
    else $error("fresh keystream block not taken at byte zero");

endmodule

[verif/tb_top.sv]
// self-checking testbench for the cenc aes-128 ctr subsample decryptor
// a cycle-free predictor (own aes-128 and subsample bookkeeping) checks every output byte
// depends on cenc_pkg and cenc_subsample_aes_ctr_decryptor
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int SettleCycles = 40;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] ivh;
    logic [63:0] ivl;
    logic        ivs;
    logic [15:0] cc;
    logic [31:0] ec;
    logic [7:0]  din;
    logic        last;
  } item_t;

  typedef struct {
    logic [7:0] data;
    logic       dec;
    logic       last;
  } byte_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic reg_index = 1'b0;
  logic [63:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [63:0] iv_high = '0, iv_low = '0;
  logic iv_short = 1'b0;
  logic [15:0] clear_count = '0;
  logic [31:0] encrypted_count = '0;
  logic [7:0] data_in = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] data_out;
  logic was_decrypted;
  logic last_out;

  cenc_subsample_aes_ctr_decryptor i_dut (.*);

  initial forever #5 clk = ~clk;

  // ---------------- predictor state ----------------
  logic [7:0]   sb [256];
  logic [127:0] aes_key;
  logic [127:0] ctr_blk;
  logic [127:0] ks_blk;
  int unsigned  ks_pos;
  logic [15:0]  clear_rem;
  logic [31:0]  enc_rem;
  logic         desc_exhausted;

  item_t       pending_items[$];
  byte_res_t   expected_bytes[$];
  int          errors = 0;
  int          sent_items = 0;
  bit          idle_mode = 1'b1;
  bit          long_hold_req = 1'b0;

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  // s-box from the field inverse and the affine map
  function automatic void build_sbox();
    logic [7:0] inv, r;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      for (int y = 1; y < 256; y++)
        if (x != 0 && gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb[x] = r;
    end
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3, rc;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8 * i -: 8];
      s[i] = blk[127 - 8 * i -: 8];
    end
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4 * (i - 1) + j];
      if ((i & 3) == 0) begin
        f = w[0];
        w[0] = sb[w[1]] ^ rc;
        w[1] = sb[w[2]];
        w[2] = sb[w[3]];
        w[3] = sb[f];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 4) + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[c * 4 + j] = sb[s[((c + j) & 3) * 4 + j]];
      for (int c = 0; c < 4; c++) begin
        if (r < 10) begin
          a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
          s[c * 4]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
          s[c * 4 + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
          s[c * 4 + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
          s[c * 4 + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
        end else begin
          for (int j = 0; j < 4; j++) s[c * 4 + j] = t[c * 4 + j];
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[16 * r + i];
    end
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
    return o;
  endfunction

  function automatic logic [7:0] next_key_byte();
    logic [7:0] b;
    if (ks_pos >= cenc_pkg::BlockBytes) begin
      ks_blk = aes_encrypt(aes_key, ctr_blk);
      ctr_blk = ctr_blk + 128'd1;
      ks_pos = 0;
    end
    b = ks_blk[127 - 8 * ks_pos -: 8];
    ks_pos++;
    return b;
  endfunction

  function automatic void decrypt_predict(input item_t it);
    byte_res_t r;
    case (it.op)
      cenc_pkg::OP_START: begin
        ctr_blk = {it.ivh, it.ivs ? 64'd0 : it.ivl};
        ks_pos = cenc_pkg::BlockBytes;
        clear_rem = 0;
        enc_rem = 0;
        desc_exhausted = 1'b1;
      end
      cenc_pkg::OP_DESC: begin
        clear_rem = it.cc;
        enc_rem = it.ec;
        desc_exhausted = 1'b0;
      end
      cenc_pkg::OP_DATA: begin
        if (!desc_exhausted && clear_rem == 0 && enc_rem == 0) desc_exhausted = 1'b1;
        if (desc_exhausted) r.dec = 1'b1;
        else if (clear_rem > 0) begin
          clear_rem--;
          r.dec = 1'b0;
        end else begin
          enc_rem--;
          r.dec = 1'b1;
        end
        r.data = r.dec ? it.din ^ next_key_byte() : it.din;
        r.last = it.last;
        expected_bytes.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------- sender ----------------
  int send_gap = 0;
  item_t cur_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) decrypt_predict(cur_item);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        op <= cur_item.op;
        iv_high <= cur_item.ivh;
        iv_low <= cur_item.ivl;
        iv_short <= cur_item.ivs;
        clear_count <= cur_item.cc;
        encrypted_count <= cur_item.ec;
        data_in <= cur_item.din;
        last_in <= cur_item.last;
        in_valid <= 1'b1;
        send_gap <= idle_mode ? $urandom_range(0, 10) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  int recv_hold = 0;
  int hold_draw = 0;
  bit long_hold_done = 1'b0;
  byte_res_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("output byte with nothing expected");
        end else begin
          want = expected_bytes.pop_front();
          if (data_out !== want.data)
            report_mismatch($sformatf("data_out %h want %h", data_out, want.data));
          if (was_decrypted !== want.dec)
            report_mismatch($sformatf("was_decrypted %b want %b", was_decrypted, want.dec));
          if (last_out !== want.last)
            report_mismatch($sformatf("last_out %b want %b", last_out, want.last));
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        recv_hold <= 300;
        out_ready <= 1'b0;
      end else if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        // a zero draw keeps ready up so results can follow back to back
        hold_draw = idle_mode ? $urandom_range(0, 10) : 0;
        recv_hold <= hold_draw;
        out_ready <= (hold_draw == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic void add(input logic [1:0] o, input logic [63:0] ivh = 0,
                              input logic [63:0] ivl = 0, input logic ivs = 0,
                              input logic [15:0] cc = 0, input logic [31:0] ec = 0,
                              input logic [7:0] din = 0, input logic last = 0);
    item_t it;
    it.op = o; it.ivh = ivh; it.ivl = ivl; it.ivs = ivs;
    it.cc = cc; it.ec = ec; it.din = din; it.last = last;
    pending_items.push_back(it);
    sent_items++;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void add_bytes(input int n, input bit mark_last);
    for (int i = 0; i < n; i++)
      add(cenc_pkg::OP_DATA, rand64(), rand64(), 1'($urandom_range(0, 1)), 16'($urandom()),
          $urandom(), 8'($urandom_range(0, 255)), mark_last && i == n - 1);
  endfunction

  // a well-formed sample: start, a few subsamples, trailing bytes
  function automatic void add_sample();
    int nsub, c, e;
    add(cenc_pkg::OP_START, rand64(), rand64(), 1'($urandom_range(0, 1)), 16'($urandom()),
        $urandom(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    nsub = $urandom_range(0, 3);
    for (int s = 0; s < nsub; s++) begin
      c = $urandom_range(0, 12);
      e = $urandom_range(0, 40);
      add(cenc_pkg::OP_DESC, rand64(), rand64(), 1'($urandom_range(0, 1)), 16'(c), 32'(e),
          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      add_bytes(c + e, 1'b0);
    end
    add_bytes($urandom_range(1, 20), 1'b1);
  endfunction

  function automatic void add_noise();
    case ($urandom_range(0, 2))
      0: add(OpUnused, rand64(), rand64(), 1'($urandom_range(0, 1)), 16'($urandom()),
             $urandom(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      1: begin
        add(cenc_pkg::OP_DESC, rand64(), rand64(), 1'($urandom_range(0, 1)), 16'($urandom()),
            $urandom(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        add_bytes($urandom_range(0, 6), 1'b0);
      end
      default: add_bytes($urandom_range(1, 5), 1'($urandom_range(0, 1)));
    endcase
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= cenc_pkg::REG_KEY_HIGH;
    write_data <= hi;
    @(posedge clk);
    reg_index <= cenc_pkg::REG_KEY_LOW;
    write_data <= lo;
    @(posedge clk);
    write_enable <= 1'b0;
    aes_key = {hi, lo};
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 7) == 0) add_noise();
      else add_sample();
      // let the sender get ahead without letting the queue run wild
      while (pending_items.size() > 64) @(posedge clk);
    end
  endtask

  initial begin
    build_sbox();
    aes_key = '0;
    ctr_blk = '0;
    ks_blk = '0;
    ks_pos = cenc_pkg::BlockBytes;
    clear_rem = 0;
    enc_rem = 0;
    desc_exhausted = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key, bytes before any start, short iv, subsample use-up,
    // replaced descriptor, unused op, counter near wrap, huge counts
    add(cenc_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h00, 0);
    add(cenc_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'hff, 1);
    add(cenc_pkg::OP_START, 64'h0123456789abcdef, 64'hffffffffffffffff, 1);
    add(cenc_pkg::OP_DESC, 0, 0, 0, 16'd2, 32'd3);
    add_bytes(7, 1'b1);
    add(OpUnused, '1, '1, 1, '1, '1, 8'hff, 1);
    add(cenc_pkg::OP_DESC, 0, 0, 0, 16'd5, 32'd5);
    add_bytes(2, 1'b0);
    add(cenc_pkg::OP_DESC, 0, 0, 0, 16'd0, 32'd2);
    add_bytes(3, 1'b1);
    add(cenc_pkg::OP_START, '1, 64'hffffffff_fffffffe, 0);
    add(cenc_pkg::OP_DESC, 0, 0, 0, 16'hffff, 32'hffffffff);
    add_bytes(2, 1'b0);
    add(cenc_pkg::OP_DESC, 0, 0, 0, 16'd0, 32'hffffffff);
    add_bytes(3, 1'b1);
    drain();

    write_key('1, '1);
    add(cenc_pkg::OP_START, '1, '1, 0);
    add(cenc_pkg::OP_DESC, 0, 0, 0, 16'd0, 32'd0);
    add_bytes(20, 1'b1);
    random_phase(150);
    drain();

    write_key(rand64(), rand64());
    idle_mode = 1'b0;
    long_hold_req <= 1'b1;
    random_phase(200);
    drain();

    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    idle_mode = 1'b1;
    random_phase(150);
    drain();

    write_key(rand64(), '0);
    random_phase(200);
    drain();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
